### design/multi_servo_pulse_generator_unit_defines.svh
// Assertion macros shared by the servo pulse generator RTL.
// Every assertion is clocked on clk_i and disabled while rst_ni is low.
`ifndef MULTI_SERVO_PULSE_GENERATOR_UNIT_DEFINES_SVH
`define MULTI_SERVO_PULSE_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property check
`define MSPG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication
`define MSPG_IMPLY(name, ante, cons, msg) \
  `MSPG_ASSERT(name, (ante) |-> (cons), msg)

`else

`define MSPG_ASSERT(name, prop, msg)
`define MSPG_IMPLY(name, ante, cons, msg)

`endif

`endif

### design/mspg_pkg.sv
package mspg_pkg;

  // Default sizes
  localparam int unsigned MAX_CHANNELS_DEF = 16;
  localparam int unsigned PIN_COUNT_DEF    = 40;

  // Field widths
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned PIN_W   = 6;
  localparam int unsigned WIDTH_W = 12;
  localparam int unsigned FRAME_W = 15;
  localparam int unsigned LEVEL_W = 40;
  localparam int unsigned COUNT_W = 5;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN = 2'd2;

  localparam logic [WIDTH_W-1:0] MIN_PULSE_RST = 12'd500;
  localparam logic [WIDTH_W-1:0] MAX_PULSE_RST = 12'd2500;
  localparam logic [FRAME_W-1:0] FRAME_LEN_RST = 15'd20000;

  // Angle scaling: width = min + (max - min) * angle / ANGLE_RANGE.
  // The division is a multiply by a rounded-up reciprocal; exact for
  // every product below 2**ANGLE_PROD_W.
  localparam int unsigned ANGLE_RANGE  = 180;
  localparam int unsigned ANGLE_W      = 8;
  localparam int unsigned ANGLE_PROD_W = WIDTH_W + ANGLE_W;
  localparam int unsigned RECIP_SHIFT  = ANGLE_PROD_W + ANGLE_W;
  localparam int unsigned ANGLE_RECIP  =
    ((1 << RECIP_SHIFT) + ANGLE_RANGE - 1) / ANGLE_RANGE;
  localparam int unsigned RECIP_W      = 21;
  localparam int unsigned SCALED_W     = ANGLE_PROD_W + RECIP_W;

  // Command codes
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK      = 3'd0,
    KIND_ATTACH    = 3'd1,
    KIND_DETACH    = 3'd2,
    KIND_SET_US    = 3'd3,
    KIND_SET_ANGLE = 3'd4,
    KIND_START     = 3'd5,
    KIND_STOP      = 3'd6
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PIN_W-1:0]   pin_number;
    logic [WIDTH_W-1:0] value;
  } servo_cmd_t;

  typedef struct packed {
    logic               ok;
    logic [LEVEL_W-1:0] pin_levels;
    logic [COUNT_W-1:0] active_count;
  } servo_rsp_t;

  // One channel table entry
  typedef struct packed {
    logic [PIN_W-1:0]   pin;
    logic [WIDTH_W-1:0] width;
  } chan_entry_t;

endpackage

### design/mspg_chan_mem.sv
// Channel table: one write port, one read port, registered read data.
module mspg_chan_mem
  import mspg_pkg::*;
#(
  parameter int unsigned DEPTH  = MAX_CHANNELS_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  chan_entry_t       wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output chan_entry_t       rd_data_o
);

  chan_entry_t chan_mem_q [DEPTH];
  chan_entry_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      chan_mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= chan_mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/mspg_angle.sv
// Angle to pulse width: min + (max - min) * angle / 180 in three stages.
`include "multi_servo_pulse_generator_unit_defines.svh"
module mspg_angle
  import mspg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [WIDTH_W-1:0] min_i,
  input  logic [WIDTH_W-1:0] diff_i,
  input  logic [ANGLE_W-1:0] angle_i,
  output logic               done_o,
  output logic [WIDTH_W-1:0] width_o
);

  logic [2:0]              vld_q;
  logic [ANGLE_PROD_W-1:0] prod_d, prod_q;
  logic [SCALED_W-1:0]     scaled_d, scaled_q;
  logic [WIDTH_W-1:0]      min1_q, min2_q;
  logic [WIDTH_W-1:0]      width_d, width_q;

  // Span times angle, then times the reciprocal of 180
  assign prod_d   = {{ANGLE_W{1'b0}}, diff_i} * {{WIDTH_W{1'b0}}, angle_i};
  assign scaled_d = {{RECIP_W{1'b0}}, prod_q} *
                    {{ANGLE_PROD_W{1'b0}}, RECIP_W'(ANGLE_RECIP)};
  assign width_d  = min2_q + scaled_q[RECIP_SHIFT +: WIDTH_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    min1_q   <= min_i;
    scaled_q <= scaled_d;
    min2_q   <= min1_q;
    width_q  <= width_d;
  end

  assign done_o  = vld_q[2];
  assign width_o = width_q;

  `MSPG_IMPLY(a_done_after_start, done_o, $past(start_i, 3), "angle result without a start")
  `MSPG_ASSERT(a_one_in_flight, $countones(vld_q) <= 1, "overlapping angle jobs")

endmodule

### design/multi_servo_pulse_generator_unit.sv
// Servo pulse generator for up to MAX_CHANNELS channels on PIN_COUNT pins.
// Commands (tick, attach, detach, set width, set angle, start, stop) enter one
// transaction at a time; each yields one result with ok, all pin levels and
// the channel count. The channel table lives in a synchronous RAM that a tick
// while running, start, attach, detach and a set that passes its range check
// walk entry by entry, one read a cycle; set-angle first runs its multiply
// pipeline. Stop, a stopped tick, an unknown code and a set that fails its
// range check go straight to the result. A finished result sits in an output
// register while the next command is taken. Configuration registers may be
// written whenever no command is busy.
`include "multi_servo_pulse_generator_unit_defines.svh"
module multi_servo_pulse_generator_unit
  import mspg_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int unsigned PIN_COUNT    = PIN_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  servo_cmd_t            in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output servo_rsp_t            out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_ATTACH,
    MODE_DETACH,
    MODE_SETW,
    MODE_RAISE,
    MODE_LOWER
  } mode_e;

  function automatic logic [PIN_COUNT-1:0] pin_onehot(input logic [PIN_W-1:0] p);
    logic [PIN_COUNT-1:0] m;
    for (int b = 0; b < PIN_COUNT; b++) begin
      m[b] = (p == PIN_W'(b));
    end
    return m;
  endfunction

  // Configuration registers
  logic [WIDTH_W-1:0] min_q, max_q;
  logic [FRAME_W-1:0] frame_len_q;

  // Block state
  state_e               state_q;
  mode_e                mode_q;
  logic [CNT_W-1:0]     chan_count_q;
  logic [FRAME_W-1:0]   frame_time_q;
  logic                 running_q;
  logic [PIN_COUNT-1:0] levels_q;
  logic [PIN_W-1:0]     cmd_pin_q;
  logic [WIDTH_W-1:0]   cmd_value_q;
  logic [CNT_W-1:0]     issue_q, data_idx_q;
  logic                 pend_q, found_q, ok_q;
  logic                 out_valid_q;
  servo_rsp_t           out_q;

  // Table access
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  chan_entry_t      mem_wdata, rd_entry;

  logic                 accept, out_free, scan_done, rd_hit, attach_ok, rd_low;
  logic [FRAME_W:0]     tick_t;
  logic [CNT_W-1:0]     idx_prev, count_fin;
  logic [PIN_COUNT-1:0] rd_mask, cmd_mask, levels_fin;
  logic                 ok_fin;
  logic [CNT_W+COUNT_W-1:0]     count_ext;
  logic [PIN_COUNT+LEVEL_W-1:0] levels_ext;
  logic                 angle_start, angle_done;
  logic [WIDTH_W-1:0]   angle_width;
  logic                 angle_bad, setus_bad, angle_range_bad;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign tick_t    = {1'b0, frame_time_q} + (FRAME_W + 1)'(1);
  assign rd_hit    = pend_q && (rd_entry.pin == cmd_pin_q);
  assign rd_mask   = pin_onehot(rd_entry.pin);
  assign cmd_mask  = pin_onehot(cmd_pin_q);
  assign rd_low    = {{(FRAME_W - WIDTH_W){1'b0}}, rd_entry.width} <= frame_time_q;
  assign idx_prev  = data_idx_q - CNT_W'(1);
  assign scan_done = (issue_q >= chan_count_q) && !pend_q;
  assign attach_ok = (chan_count_q < CNT_W'(MAX_CHANNELS)) &&
                     ({1'b0, cmd_pin_q} < (PIN_W + 1)'(PIN_COUNT)) && !found_q;

  assign setus_bad       = (in_data_i.value < min_q) || (in_data_i.value > max_q);
  assign angle_range_bad = (in_data_i.value > WIDTH_W'(ANGLE_RANGE)) || (max_q < min_q);
  assign angle_bad       = (angle_width < min_q) || (angle_width > max_q);
  assign angle_start     = accept && (in_data_i.kind == KIND_SET_ANGLE) && !angle_range_bad;

  // One read per cycle while walking the table
  assign mem_re    = (state_q == ST_SCAN) && (issue_q < chan_count_q);
  assign mem_raddr = issue_q[IDX_W-1:0];

  // Writes: detach moves later entries down by one, set rewrites the hit,
  // attach appends. Reads always run ahead of writes, so no entry is read
  // and written in the same cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = data_idx_q[IDX_W-1:0];
    mem_wdata = '{pin: cmd_pin_q, width: cmd_value_q};
    if (state_q == ST_SCAN && pend_q) begin
      if (mode_q == MODE_DETACH && found_q) begin
        mem_we    = 1'b1;
        mem_waddr = idx_prev[IDX_W-1:0];
        mem_wdata = rd_entry;
      end else if (mode_q == MODE_SETW && rd_hit) begin
        mem_we = 1'b1;
      end
    end else if (state_q == ST_FINISH && out_free && mode_q == MODE_ATTACH && attach_ok) begin
      mem_we    = 1'b1;
      mem_waddr = chan_count_q[IDX_W-1:0];
    end
  end

  // End-of-command results
  always_comb begin
    count_fin  = chan_count_q;
    levels_fin = levels_q;
    ok_fin     = ok_q;
    case (mode_q)
      MODE_ATTACH: begin
        ok_fin = attach_ok;
        if (attach_ok) begin
          count_fin  = chan_count_q + CNT_W'(1);
          levels_fin = levels_q & ~cmd_mask;
        end
      end
      MODE_DETACH: begin
        ok_fin = found_q;
        if (found_q) begin
          count_fin = chan_count_q - CNT_W'(1);
        end
      end
      MODE_SETW: ok_fin = found_q;
      default: ;
    endcase
  end

  assign count_ext  = {{COUNT_W{1'b0}}, count_fin};
  assign levels_ext = {{LEVEL_W{1'b0}}, levels_fin};

  mspg_chan_mem #(
    .DEPTH  (MAX_CHANNELS),
    .ADDR_W (IDX_W)
  ) u_chan_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (rd_entry)
  );

  mspg_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (angle_start),
    .min_i   (min_q),
    .diff_i  (max_q - min_q),
    .angle_i (in_data_i.value[ANGLE_W-1:0]),
    .done_o  (angle_done),
    .width_o (angle_width)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= MIN_PULSE_RST;
      max_q       <= MAX_PULSE_RST;
      frame_len_q <= FRAME_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_PULSE: min_q       <= cfg_data_i[WIDTH_W-1:0];
        CFG_MAX_PULSE: max_q       <= cfg_data_i[WIDTH_W-1:0];
        CFG_FRAME_LEN: frame_len_q <= cfg_data_i[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Command sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_q       <= MODE_NONE;
      chan_count_q <= '0;
      frame_time_q <= '0;
      running_q    <= 1'b0;
      levels_q     <= '0;
      cmd_pin_q    <= '0;
      cmd_value_q  <= '0;
      issue_q      <= '0;
      data_idx_q   <= '0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      ok_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      pend_q     <= mem_re;
      data_idx_q <= issue_q;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_pin_q   <= in_data_i.pin_number;
            cmd_value_q <= in_data_i.value;
            issue_q     <= '0;
            found_q     <= 1'b0;
            ok_q        <= 1'b1;
            mode_q      <= MODE_NONE;
            state_q     <= ST_FINISH;
            case (in_data_i.kind)
              KIND_TICK: begin
                if (running_q) begin
                  state_q <= ST_SCAN;
                  if (tick_t >= {1'b0, frame_len_q}) begin
                    frame_time_q <= '0;
                    mode_q       <= MODE_RAISE;
                  end else begin
                    frame_time_q <= tick_t[FRAME_W-1:0];
                    mode_q       <= MODE_LOWER;
                  end
                end
              end
              KIND_ATTACH: begin
                mode_q  <= MODE_ATTACH;
                state_q <= ST_SCAN;
              end
              KIND_DETACH: begin
                mode_q  <= MODE_DETACH;
                state_q <= ST_SCAN;
              end
              KIND_SET_US: begin
                if (setus_bad) begin
                  ok_q <= 1'b0;
                end else begin
                  mode_q  <= MODE_SETW;
                  state_q <= ST_SCAN;
                end
              end
              KIND_SET_ANGLE: begin
                if (angle_range_bad) begin
                  ok_q <= 1'b0;
                end else begin
                  state_q <= ST_ANGLE;
                end
              end
              KIND_START: begin
                running_q    <= 1'b1;
                frame_time_q <= '0;
                mode_q       <= MODE_RAISE;
                state_q      <= ST_SCAN;
              end
              KIND_STOP: running_q <= 1'b0;
              default: ok_q <= 1'b0;
            endcase
          end
        end
        ST_ANGLE: begin
          if (angle_done) begin
            cmd_value_q <= angle_width;
            if (angle_bad) begin
              ok_q    <= 1'b0;
              state_q <= ST_FINISH;
            end else begin
              mode_q  <= MODE_SETW;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (mem_re) begin
            issue_q <= issue_q + CNT_W'(1);
          end
          if (rd_hit) begin
            found_q <= 1'b1;
          end
          if (pend_q) begin
            case (mode_q)
              MODE_RAISE: levels_q <= levels_q | rd_mask;
              MODE_LOWER: begin
                if (rd_low) begin
                  levels_q <= levels_q & ~rd_mask;
                end
              end
              default: ;
            endcase
          end
          if (scan_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            chan_count_q           <= count_fin;
            levels_q               <= levels_fin;
            out_q.ok               <= ok_fin;
            out_q.pin_levels       <= levels_ext[LEVEL_W-1:0];
            out_q.active_count     <= count_ext[COUNT_W-1:0];
            out_valid_q            <= 1'b1;
            state_q                <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MSPG_ASSERT(a_count_bound, chan_count_q <= CNT_W'(MAX_CHANNELS), "channel count overflow")
  `MSPG_ASSERT(a_no_rw_clash,
               !(mem_we && mem_re && (mem_waddr == mem_raddr)),
               "table read/write clash")
  `MSPG_IMPLY(a_read_in_scan, mem_re, state_q == ST_SCAN, "table read outside a walk")
  `MSPG_ASSERT(a_count_step,
               (chan_count_q == $past(chan_count_q)) ||
               (chan_count_q == $past(chan_count_q) + CNT_W'(1)) ||
               (chan_count_q + CNT_W'(1) == $past(chan_count_q)),
               "channel count jumped")

endmodule
